// ===== hdl/cvdp_pkg.sv =====
// ----------------------------------------------------------------------------
// cvdp_pkg: shared types and constants of the color vector dot product core
// Field widths, intermediate widths, register indexes and mode codes.
// ----------------------------------------------------------------------------
package cvdp_pkg;

  // Width of one complex component, signed Q1.22.
  localparam int COMP_W = 24;
  // One product of two components, Q3.44.
  localparam int PROD_W = 2 * COMP_W;
  // Sum or difference of two products within one lane.
  localparam int LANE_W = PROD_W + 1;
  // Sum over the three color lanes.
  localparam int TERM_W = LANE_W + 2;
  // Accumulator and result width.
  localparam int ACC_W = 64;
  // Site counter and site_count register width.
  localparam int CNT_W = 21;
  localparam logic [CNT_W-1:0] MAX_SITES = 21'd1048576;
  localparam logic [CNT_W-1:0] SITE_COUNT_RESET = 21'd1048576;
  localparam int NUM_LANES = 3;

  // Configuration port.
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = CNT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SITE_COUNT = 4'd0,
    REG_MODE       = 4'd1
  } cfg_reg_e;

  // The fourth code behaves as the squared norm.
  typedef enum logic [1:0] {
    MODE_DOT      = 2'd0,
    MODE_REAL     = 2'd1,
    MODE_NORM     = 2'd2,
    MODE_NORM_ALT = 2'd3
  } mode_e;

  // Control that travels with each word down the pipeline.
  typedef struct packed {
    logic  valid;
    mode_e mode;
  } ctl_t;

endpackage

// ===== hdl/cvdp_lane.sv =====
// ----------------------------------------------------------------------------
// cvdp_lane: one color lane of the dot product
// Forms the four products of one color and their real and imaginary sums.
// ----------------------------------------------------------------------------
module cvdp_lane (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic                               square_i,
  input  logic signed [cvdp_pkg::COMP_W-1:0] ar_i,
  input  logic signed [cvdp_pkg::COMP_W-1:0] ai_i,
  input  logic signed [cvdp_pkg::COMP_W-1:0] br_i,
  input  logic signed [cvdp_pkg::COMP_W-1:0] bi_i,
  output logic signed [cvdp_pkg::LANE_W-1:0] re_o,
  output logic signed [cvdp_pkg::LANE_W-1:0] im_o
);

  localparam int CompW = cvdp_pkg::COMP_W;
  localparam int ProdW = cvdp_pkg::PROD_W;
  localparam int LaneW = cvdp_pkg::LANE_W;

  logic signed [CompW-1:0] mul_re;
  logic signed [CompW-1:0] mul_im;
  logic signed [ProdW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [LaneW-1:0] re_q, im_q;

  // For the squared norm, a is multiplied by itself.
  assign mul_re = square_i ? ar_i : br_i;
  assign mul_im = square_i ? ai_i : bi_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_rr_q <= ProdW'(ar_i) * ProdW'(mul_re);
      p_ii_q <= ProdW'(ai_i) * ProdW'(mul_im);
      p_ri_q <= ProdW'(ar_i) * ProdW'(bi_i);
      p_ir_q <= ProdW'(ai_i) * ProdW'(br_i);
      // conj(a) * b = (ar*br + ai*bi) + i (ar*bi - ai*br)
      re_q   <= LaneW'(p_rr_q) + LaneW'(p_ii_q);
      im_q   <= LaneW'(p_ri_q) - LaneW'(p_ir_q);
    end
  end

  assign re_o = re_q;
  assign im_o = im_q;

endmodule

// ===== hdl/cvdp_merge.sv =====
// ----------------------------------------------------------------------------
// cvdp_merge: lane merging stage
// Adds the per-lane sums of all colors into one site term.
// ----------------------------------------------------------------------------
module cvdp_merge (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [cvdp_pkg::LANE_W-1:0] re_i [cvdp_pkg::NUM_LANES],
  input  logic signed [cvdp_pkg::LANE_W-1:0] im_i [cvdp_pkg::NUM_LANES],
  output logic signed [cvdp_pkg::TERM_W-1:0] term_re_o,
  output logic signed [cvdp_pkg::TERM_W-1:0] term_im_o
);

  localparam int TermW = cvdp_pkg::TERM_W;

  logic signed [TermW-1:0] sum_re, sum_im;
  logic signed [TermW-1:0] term_re_q, term_im_q;

  always_comb begin
    sum_re = '0;
    sum_im = '0;
    for (int l = 0; l < cvdp_pkg::NUM_LANES; l++) begin
      sum_re = sum_re + TermW'(re_i[l]);
      sum_im = sum_im + TermW'(im_i[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_re_q <= sum_re;
      term_im_q <= sum_im;
    end
  end

  assign term_re_o = term_re_q;
  assign term_im_o = term_im_q;

endmodule

// ===== hdl/cvdp_accum.sv =====
// ----------------------------------------------------------------------------
// cvdp_accum: saturating accumulators, site counter and result register
// Adds each site term, counts sites and hands over the totals.
// ----------------------------------------------------------------------------
module cvdp_accum (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  cvdp_pkg::mode_e                    mode_i,
  input  logic signed [cvdp_pkg::TERM_W-1:0] term_re_i,
  input  logic signed [cvdp_pkg::TERM_W-1:0] term_im_i,
  input  logic        [cvdp_pkg::CNT_W-1:0]  site_count_i,
  output logic                               ready_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [cvdp_pkg::ACC_W-1:0]  sum_re_o,
  output logic signed [cvdp_pkg::ACC_W-1:0]  sum_im_o,
  output logic                               overflow_o
);

  localparam int AccW  = cvdp_pkg::ACC_W;
  localparam int ExtW  = AccW + 1;
  localparam int TermW = cvdp_pkg::TERM_W;
  localparam int CntW  = cvdp_pkg::CNT_W;

  typedef struct packed {
    logic            ovf;
    logic [AccW-1:0] val;
  } sat_t;

  // Exact sum clamped to the signed accumulator range.
  function automatic sat_t sat_add(input logic signed [AccW-1:0] acc,
                                   input logic signed [TermW-1:0] term);
    logic signed [ExtW-1:0] sum;
    sat_t res;
    sum = ExtW'(acc) + ExtW'(term);
    res.ovf = sum[ExtW-1] ^ sum[ExtW-2];
    if (!res.ovf) begin
      res.val = sum[AccW-1:0];
    end else if (sum[ExtW-1]) begin
      res.val = {1'b1, {(AccW-1){1'b0}}};
    end else begin
      res.val = {1'b0, {(AccW-1){1'b1}}};
    end
    return res;
  endfunction

  logic signed [AccW-1:0] acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic [CntW-1:0]        seen_q, seen_d, seen_inc, limit;
  logic                   flag_q, flag_d;
  logic                   out_valid_q, out_valid_d;
  logic signed [AccW-1:0] out_re_q, out_im_q;
  logic                   out_ovf_q;
  logic                   is_dot, last, take;
  sat_t                   add_re, add_im;
  logic                   flag_new;

  assign is_dot   = (mode_i == cvdp_pkg::MODE_DOT);
  assign limit    = (site_count_i == '0 || site_count_i > cvdp_pkg::MAX_SITES) ?
                    cvdp_pkg::MAX_SITES : site_count_i;
  assign seen_inc = seen_q + CntW'(1);
  assign last     = (seen_inc >= limit);

  // Hold the term only when it closes a reduction and the result slot holds a word that is not being taken.
  assign ready_o  = !(valid_i && last && out_valid_q && !out_ready_i);
  assign take     = valid_i && ready_o;

  assign add_re   = sat_add(acc_re_q, term_re_i);
  assign add_im   = sat_add(acc_im_q, term_im_i);
  assign flag_new = flag_q | add_re.ovf | (is_dot & add_im.ovf);

  always_comb begin
    acc_re_d    = acc_re_q;
    acc_im_d    = acc_im_q;
    seen_d      = seen_q;
    flag_d      = flag_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (take) begin
      if (last) begin
        acc_re_d    = '0;
        acc_im_d    = '0;
        seen_d      = '0;
        flag_d      = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        acc_re_d = add_re.val;
        acc_im_d = is_dot ? add_im.val : acc_im_q;
        seen_d   = seen_inc;
        flag_d   = flag_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q    <= '0;
      acc_im_q    <= '0;
      seen_q      <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_re_q    <= acc_re_d;
      acc_im_q    <= acc_im_d;
      seen_q      <= seen_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && last) begin
      out_re_q  <= add_re.val;
      out_im_q  <= is_dot ? add_im.val : '0;
      out_ovf_q <= flag_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sum_re_o    = out_re_q;
  assign sum_im_o    = out_im_q;
  assign overflow_o  = out_ovf_q;

endmodule

// ===== hdl/color_vector_dot_product_core.sv =====
// ----------------------------------------------------------------------------
// color_vector_dot_product_core: streaming color vector dot product reduction
// Path: a closing site word passes the product, lane sum, lane merge and
// accumulate registers before its result word is valid.
// Throughput: one site word per cycle; the four-stage pipeline stalls only when
// a reduction closes while the previous result word is still held.
// Reset: asynchronous, active low; clears accumulators, counter, sticky flag,
// pipeline valids and sets site_count to 1048576 and mode to complex dot.
// ----------------------------------------------------------------------------
module color_vector_dot_product_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write channel.
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic        [cvdp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [cvdp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Site input channel.
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [cvdp_pkg::COMP_W-1:0]    a0_re_i,
  input  logic signed [cvdp_pkg::COMP_W-1:0]    a0_im_i,
  input  logic signed [cvdp_pkg::COMP_W-1:0]    a1_re_i,
  input  logic signed [cvdp_pkg::COMP_W-1:0]    a1_im_i,
  input  logic signed [cvdp_pkg::COMP_W-1:0]    a2_re_i,
  input  logic signed [cvdp_pkg::COMP_W-1:0]    a2_im_i,
  input  logic signed [cvdp_pkg::COMP_W-1:0]    b0_re_i,
  input  logic signed [cvdp_pkg::COMP_W-1:0]    b0_im_i,
  input  logic signed [cvdp_pkg::COMP_W-1:0]    b1_re_i,
  input  logic signed [cvdp_pkg::COMP_W-1:0]    b1_im_i,
  input  logic signed [cvdp_pkg::COMP_W-1:0]    b2_re_i,
  input  logic signed [cvdp_pkg::COMP_W-1:0]    b2_im_i,
  // Result output channel.
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [cvdp_pkg::ACC_W-1:0]     sum_re_o,
  output logic signed [cvdp_pkg::ACC_W-1:0]     sum_im_o,
  output logic                                  overflow_o
);

  localparam int NumLanes = cvdp_pkg::NUM_LANES;

  // Configuration registers. Writes are taken in every cycle; the port must
  // only be written while no site word is in flight (the user's duty, the
  // block does not enforce it), so the pipeline can read the registers directly.
  logic [cvdp_pkg::CNT_W-1:0] site_count_q;
  cvdp_pkg::mode_e            mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_count_q <= cvdp_pkg::SITE_COUNT_RESET;
      mode_q       <= cvdp_pkg::MODE_DOT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cvdp_pkg::REG_SITE_COUNT: site_count_q <= cfg_data_i;
        cvdp_pkg::REG_MODE:       mode_q <= cvdp_pkg::mode_e'(cfg_data_i[1:0]);
        default: ;  // Indexes past the register list are dropped.
      endcase
    end
  end

  // Pipeline control. The whole pipeline moves on one enable, which the
  // accumulator drops only when a closing site meets a held result word.
  cvdp_pkg::ctl_t ctl1_q, ctl2_q, ctl3_q;
  logic           en;
  logic           square;

  assign in_ready_o = en;
  assign square = (mode_q == cvdp_pkg::MODE_NORM) || (mode_q == cvdp_pkg::MODE_NORM_ALT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '{valid: 1'b0, mode: cvdp_pkg::MODE_DOT};
      ctl2_q <= '{valid: 1'b0, mode: cvdp_pkg::MODE_DOT};
      ctl3_q <= '{valid: 1'b0, mode: cvdp_pkg::MODE_DOT};
    end else if (en) begin
      ctl1_q <= '{valid: in_valid_i, mode: mode_q};
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
    end
  end

  // Color lanes: each lane owns one color of a and b and produces the real
  // and imaginary contributions of that color through its product and sum registers.
  logic signed [cvdp_pkg::COMP_W-1:0] a_re [NumLanes];
  logic signed [cvdp_pkg::COMP_W-1:0] a_im [NumLanes];
  logic signed [cvdp_pkg::COMP_W-1:0] b_re [NumLanes];
  logic signed [cvdp_pkg::COMP_W-1:0] b_im [NumLanes];
  logic signed [cvdp_pkg::LANE_W-1:0] lane_re [NumLanes];
  logic signed [cvdp_pkg::LANE_W-1:0] lane_im [NumLanes];

  assign a_re[0] = a0_re_i;
  assign a_im[0] = a0_im_i;
  assign a_re[1] = a1_re_i;
  assign a_im[1] = a1_im_i;
  assign a_re[2] = a2_re_i;
  assign a_im[2] = a2_im_i;
  assign b_re[0] = b0_re_i;
  assign b_im[0] = b0_im_i;
  assign b_re[1] = b1_re_i;
  assign b_im[1] = b1_im_i;
  assign b_re[2] = b2_re_i;
  assign b_im[2] = b2_im_i;

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    cvdp_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .square_i (square),
      .ar_i     (a_re[l]),
      .ai_i     (a_im[l]),
      .br_i     (b_re[l]),
      .bi_i     (b_im[l]),
      .re_o     (lane_re[l]),
      .im_o     (lane_im[l])
    );
  end

  // Merge the three lanes into one site term.
  logic signed [cvdp_pkg::TERM_W-1:0] term_re, term_im;

  cvdp_merge u_merge (
    .clk_i     (clk_i),
    .en_i      (en),
    .re_i      (lane_re),
    .im_i      (lane_im),
    .term_re_o (term_re),
    .term_im_o (term_im)
  );

  // Accumulate, count sites and present the totals. The result register
  // parts the output channel from the pipeline, so site words that do not
  // close a run keep flowing while a finished result word waits to be taken.
  cvdp_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (ctl3_q.valid),
    .mode_i       (ctl3_q.mode),
    .term_re_i    (term_re),
    .term_im_i    (term_im),
    .site_count_i (site_count_q),
    .ready_o      (en),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sum_re_o     (sum_re_o),
    .sum_im_o     (sum_im_o),
    .overflow_o   (overflow_o)
  );

`ifndef NO_ASSERTIONS
  // An accepted site word must enter the first stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ctl1_q.valid)
    else $error("accepted site word did not enter the pipeline");

  // A word in stage two moves to the accumulate stage whenever the pipeline advances.
  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && ctl2_q.valid |=> ctl3_q.valid)
    else $error("site word lost between merge and accumulate stages");

  // A new result word only appears after a site word sat in the accumulate stage.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(ctl3_q.valid))
    else $error("result word appeared without a site word to close it");
`endif

endmodule

// ===== bench/tb_color_vector_dot_product_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_color_vector_dot_product_core: self-checking bench for the dot product core
// Walks a short table of hand-picked site words and register writes, then
// drives random site words under several idling patterns. Every site word that
// the core accepts is folded into a software copy of the reduction. Every
// result word is checked field by field against the oldest expected total.
// ----------------------------------------------------------------------------
module tb_color_vector_dot_product_core;

  // Run limits.
  localparam int CYCLE_LIMIT = 100_000;
  // Cycles the core may still be busy after the last expected total arrived.
  // The pipeline is four stages deep, so this leaves some margin.
  localparam int QUIET_CYCLES = 8;
  // Length of the long receiver hold-off that fills the pipeline.
  localparam int HOLD_CYCLES = 300;

  // A register index that decodes to nothing.
  localparam logic [cvdp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

  typedef logic signed [cvdp_pkg::COMP_W-1:0] comp_t;

  localparam comp_t COMP_MAX = 24'h7F_FFFF;
  localparam comp_t COMP_MIN = 24'h80_0000;
  localparam comp_t COMP_HALF = 24'h40_0000;

  localparam longint TERM_LIMIT = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = -TERM_LIMIT - 1;

  // Idling per phase of the random part, in percent of cycles.
  localparam int TX_IDLE_PCT [4] = '{0, 79, 0, 27};
  localparam int RX_STALL_PCT [4] = '{0, 0, 79, 27};

  // One lattice site in port order.
  typedef struct packed {
    comp_t a0_re, a0_im, a1_re, a1_im, a2_re, a2_im;
    comp_t b0_re, b0_im, b1_re, b1_im, b2_re, b2_im;
  } site_t;

  // One result word.
  typedef struct packed {
    logic signed [cvdp_pkg::ACC_W-1:0] sum_re;
    logic signed [cvdp_pkg::ACC_W-1:0] sum_im;
    logic                              overflow;
  } total_t;

  typedef enum logic {ROW_SITE, ROW_CFG} row_kind_e;

  // One row of the directed table: either a register write or a site word.
  // Where typed is set, total is the hand-computed result of the run that
  // this site word closes, and it replaces the predicted one.
  typedef struct {
    row_kind_e                       kind;
    logic [cvdp_pkg::CFG_IDX_W-1:0]  idx;
    logic [cvdp_pkg::CFG_DATA_W-1:0] data;
    site_t                           site;
    bit                              typed;
    total_t                          total;
  } step_t;

  // Clock, reset and everything the bench drives start at known values.
  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [cvdp_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [cvdp_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  comp_t a0_re_i = '0, a0_im_i = '0, a1_re_i = '0, a1_im_i = '0;
  comp_t a2_re_i = '0, a2_im_i = '0, b0_re_i = '0, b0_im_i = '0;
  comp_t b1_re_i = '0, b1_im_i = '0, b2_re_i = '0, b2_im_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [cvdp_pkg::ACC_W-1:0] sum_re_o;
  logic signed [cvdp_pkg::ACC_W-1:0] sum_im_o;
  logic overflow_o;

  color_vector_dot_product_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Software copy of the reduction. The register copies change only when a
  // write word is accepted; the running sums change when a site word is.
  // --------------------------------------------------------------------------
  logic [cvdp_pkg::CNT_W-1:0] cfg_site_count = cvdp_pkg::SITE_COUNT_RESET;
  cvdp_pkg::mode_e            cfg_mode = cvdp_pkg::MODE_DOT;
  longint                     run_re = 0;
  longint                     run_im = 0;
  logic [cvdp_pkg::CNT_W-1:0] sites_in_run = '0;
  logic                       run_saturated = 1'b0;

  // Totals that the core still owes, oldest first.
  total_t pending_totals[$];
  int     mismatches = 0;

  // Idling knobs. The sender's is read only by the stimulus process; the
  // receiver's is written with nonblocking assignments so that the receiver
  // process picks up a change at a well-defined edge.
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  // Each increment asks the receiver for one long hold-off.
  int hold_req = 0;

  // Adds y to x and clamps to [lo, hi]; any clamp marks the run as saturated.
  function automatic longint clamp_add(longint x, longint y, longint lo, longint hi);
    logic signed [cvdp_pkg::ACC_W:0] s;
    s = (cvdp_pkg::ACC_W + 1)'(x) + (cvdp_pkg::ACC_W + 1)'(y);
    if (s > hi) begin
      run_saturated = 1'b1;
      return hi;
    end
    if (s < lo) begin
      run_saturated = 1'b1;
      return lo;
    end
    return longint'(s[cvdp_pkg::ACC_W-1:0]);
  endfunction

  // Folds one accepted site into the running sums. Returns 1 when this site
  // closes the run, with the result word in t, and starts a fresh run.
  function automatic bit fold_site(site_t s, output total_t t);
    longint                     ar[cvdp_pkg::NUM_LANES];
    longint                     ai[cvdp_pkg::NUM_LANES];
    longint                     br[cvdp_pkg::NUM_LANES];
    longint                     bi[cvdp_pkg::NUM_LANES];
    longint                     term_re, term_im;
    logic [cvdp_pkg::CNT_W-1:0] limit;
    ar[0] = longint'(s.a0_re); ai[0] = longint'(s.a0_im);
    br[0] = longint'(s.b0_re); bi[0] = longint'(s.b0_im);
    ar[1] = longint'(s.a1_re); ai[1] = longint'(s.a1_im);
    br[1] = longint'(s.b1_re); bi[1] = longint'(s.b1_im);
    ar[2] = longint'(s.a2_re); ai[2] = longint'(s.a2_im);
    br[2] = longint'(s.b2_re); bi[2] = longint'(s.b2_im);
    term_re = 0;
    term_im = 0;
    for (int c = 0; c < cvdp_pkg::NUM_LANES; c++) begin
      if (cfg_mode == cvdp_pkg::MODE_NORM || cfg_mode == cvdp_pkg::MODE_NORM_ALT) begin
        // Squared norm of a: the b half of the word plays no part.
        term_re = clamp_add(term_re, ar[c] * ar[c], -TERM_LIMIT, TERM_LIMIT);
        term_re = clamp_add(term_re, ai[c] * ai[c], -TERM_LIMIT, TERM_LIMIT);
      end else begin
        // conj(a) * b = (ar*br + ai*bi) + i (ar*bi - ai*br)
        term_re = clamp_add(term_re, ar[c] * br[c], -TERM_LIMIT, TERM_LIMIT);
        term_re = clamp_add(term_re, ai[c] * bi[c], -TERM_LIMIT, TERM_LIMIT);
        if (cfg_mode == cvdp_pkg::MODE_DOT) begin
          term_im = clamp_add(term_im, ar[c] * bi[c], -TERM_LIMIT, TERM_LIMIT);
          term_im = clamp_add(term_im, -(ai[c] * br[c]), -TERM_LIMIT, TERM_LIMIT);
        end
      end
    end
    run_re = clamp_add(run_re, term_re, ACC_MIN, TERM_LIMIT);
    // The imaginary sum is held, not cleared, while a real-only mode is set.
    if (cfg_mode == cvdp_pkg::MODE_DOT)
      run_im = clamp_add(run_im, term_im, ACC_MIN, TERM_LIMIT);

    // A count of zero, or one above the maximum, means the maximum.
    limit = cfg_site_count;
    if (limit == 0 || limit > cvdp_pkg::MAX_SITES)
      limit = cvdp_pkg::MAX_SITES;
    // If the count was lowered below the sites already taken, this closes now.
    sites_in_run = sites_in_run + 1'b1;
    if (sites_in_run < limit)
      return 1'b0;

    t.sum_re = run_re;
    t.sum_im = (cfg_mode == cvdp_pkg::MODE_DOT) ? run_im : 64'sd0;
    t.overflow = run_saturated;
    run_re = 0;
    run_im = 0;
    sites_in_run = '0;
    run_saturated = 1'b0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Site word builders for the table and the random part.
  // --------------------------------------------------------------------------
  function automatic site_t fill(comp_t a, comp_t b);
    return '{a, a, a, a, a, a, b, b, b, b, b, b};
  endfunction

  // Only color 0 carries data; the other colors are zero.
  function automatic site_t pair(comp_t ar, comp_t ai, comp_t br, comp_t bi);
    site_t s;
    s = '0;
    s.a0_re = ar;
    s.a0_im = ai;
    s.b0_re = br;
    s.b0_im = bi;
    return s;
  endfunction

  // Extremes and zero come up often; the rest is spread over the full range.
  function automatic comp_t rand_comp();
    logic [31:0] r;
    r = $urandom;
    unique case ($urandom_range(7))
      0:       return COMP_MIN;
      1:       return COMP_MAX;
      2:       return '0;
      default: return r[cvdp_pkg::COMP_W-1:0];
    endcase
  endfunction

  function automatic site_t rand_site();
    return '{rand_comp(), rand_comp(), rand_comp(), rand_comp(),
             rand_comp(), rand_comp(), rand_comp(), rand_comp(),
             rand_comp(), rand_comp(), rand_comp(), rand_comp()};
  endfunction

  function automatic step_t site_row(site_t s);
    step_t r;
    r.kind = ROW_SITE;
    r.idx = '0;
    r.data = '0;
    r.site = s;
    r.typed = 1'b0;
    r.total = '0;
    return r;
  endfunction

  function automatic step_t known_row(site_t s, logic signed [cvdp_pkg::ACC_W-1:0] re,
                                      logic signed [cvdp_pkg::ACC_W-1:0] im, logic ovf);
    step_t r;
    r = site_row(s);
    r.typed = 1'b1;
    r.total = '{re, im, ovf};
    return r;
  endfunction

  function automatic step_t cfg_row(logic [cvdp_pkg::CFG_IDX_W-1:0] idx,
                                    logic [cvdp_pkg::CFG_DATA_W-1:0] data);
    step_t r;
    r = site_row('0);
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic step_t mode_row(cvdp_pkg::mode_e m);
    return cfg_row(cvdp_pkg::REG_MODE, cvdp_pkg::CFG_DATA_W'(m));
  endfunction

  // --------------------------------------------------------------------------
  // Driving tasks. All of them are entered just after a rising edge and drive
  // with nonblocking assignments, so the core sees the new values at the next
  // edge. Handshake signals are sampled right after the edge, before any
  // nonblocking update of that step, so they read as they were at the edge.
  // --------------------------------------------------------------------------

  // Offers one site word, with random idle cycles ahead of it, and holds it
  // until accepted. Valid stays high on return so that a following word can
  // go out back to back; every other caller lowers it first.
  task automatic send_site(input site_t s, output bit closes, output total_t t);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {a0_re_i, a0_im_i, a1_re_i, a1_im_i, a2_re_i, a2_im_i,
     b0_re_i, b0_im_i, b1_re_i, b1_im_i, b2_re_i, b2_im_i} <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    closes = fold_site(s, t);
  endtask

  // Stops sending, waits for every owed total, then lets the pipeline empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_totals.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // Register writes happen only with the core idle.
  task automatic write_reg(logic [cvdp_pkg::CFG_IDX_W-1:0] idx,
                           logic [cvdp_pkg::CFG_DATA_W-1:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == cvdp_pkg::REG_SITE_COUNT)
      cfg_site_count = data;
    else if (idx == cvdp_pkg::REG_MODE)
      cfg_mode = cvdp_pkg::mode_e'(data[1:0]);
  endtask

  // --------------------------------------------------------------------------
  // Receiver. Stalls at the current random rate, or for one long stretch when
  // a hold-off is requested. The hold-off is counted here, in its own process,
  // so the sender keeps offering words while the result path is blocked.
  // --------------------------------------------------------------------------
  int hold_ack = 0;
  int hold_left = 0;

  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker. Each accepted result word is matched against the oldest
  // owed total; a word with nothing owed is itself a failure.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_totals
    total_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_totals.size() == 0) begin
        $display("%0t: result word with none expected: sum_re %0d sum_im %0d overflow %0b",
                 $time, sum_re_o, sum_im_o, overflow_o);
        mismatches++;
      end else begin
        want = pending_totals.pop_front();
        if (sum_re_o !== want.sum_re) begin
          $display("%0t: sum_re expected %0d, got %0d", $time, want.sum_re, sum_re_o);
          mismatches++;
        end
        if (sum_im_o !== want.sum_im) begin
          $display("%0t: sum_im expected %0d, got %0d", $time, want.sum_im, sum_im_o);
          mismatches++;
        end
        if (overflow_o !== want.overflow) begin
          $display("%0t: overflow expected %0b, got %0b", $time, want.overflow,
                   overflow_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a total that never comes ends the run here.
  int cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d totals still owed", cycle_count,
               pending_totals.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  step_t plan[$];

  initial begin : stimulus
    bit                              closes;
    total_t                          predicted;
    int                              pick;
    logic [cvdp_pkg::CFG_DATA_W-1:0] count;

    // Directed table. Typed totals are those that follow at a glance from the
    // extremes: all-minimum components give 2^46 per product, and a half in
    // Q1.22 times a half gives 2^44.
    plan = '{
      // Power-on settings: complex dot over 1048576 sites, so nothing closes.
      site_row(fill('0, '0)),
      site_row(fill(COMP_MAX, COMP_MAX)),
      site_row(rand_site()),
      // A count below the sites already taken closes the run on the next word.
      cfg_row(cvdp_pkg::REG_SITE_COUNT, 21'd1),
      site_row(fill('0, '0)),
      // One site per run from here on.
      known_row(fill(COMP_MIN, COMP_MIN), 64'sh0001_8000_0000_0000, 64'sd0, 1'b0),
      site_row(fill(COMP_MIN, COMP_MAX)),
      known_row(pair(COMP_HALF, '0, '0, COMP_HALF), 64'sd0,
                64'sh0000_1000_0000_0000, 1'b0),
      // Real part only: the imaginary field reads zero.
      mode_row(cvdp_pkg::MODE_REAL),
      site_row(rand_site()),
      known_row(pair('0, COMP_HALF, '0, COMP_HALF), 64'sh0000_1000_0000_0000,
                64'sd0, 1'b0),
      // Squared norm of a, with b at the opposite extreme to show it is unused.
      mode_row(cvdp_pkg::MODE_NORM),
      known_row(fill(COMP_MIN, COMP_MAX), 64'sh0001_8000_0000_0000, 64'sd0, 1'b0),
      site_row(fill(COMP_MAX, COMP_MIN)),
      // The spare mode code behaves as the squared norm.
      mode_row(cvdp_pkg::MODE_NORM_ALT),
      known_row(pair(COMP_HALF, '0, COMP_MAX, COMP_MIN), 64'sh0000_1000_0000_0000,
                64'sd0, 1'b0),
      // A write to an index with no register behind it changes nothing.
      cfg_row(REG_UNUSED, '0),
      known_row(pair(COMP_HALF, '0, COMP_MAX, COMP_MIN), 64'sh0000_1000_0000_0000,
                64'sd0, 1'b0),
      // A count of zero acts as the maximum: three sites, no result, until the
      // count is lowered below them.
      mode_row(cvdp_pkg::MODE_DOT),
      cfg_row(cvdp_pkg::REG_SITE_COUNT, 21'd0),
      site_row(rand_site()),
      site_row(rand_site()),
      site_row(rand_site()),
      cfg_row(cvdp_pkg::REG_SITE_COUNT, 21'd2),
      site_row(rand_site()),
      // The all-ones count is above the maximum and acts as it too.
      cfg_row(cvdp_pkg::REG_SITE_COUNT, 21'h1F_FFFF),
      site_row(rand_site()),
      site_row(rand_site()),
      cfg_row(cvdp_pkg::REG_SITE_COUNT, 21'd1),
      site_row(rand_site()),
      // Mode changes inside a run: the imaginary sum skips the middle site.
      cfg_row(cvdp_pkg::REG_SITE_COUNT, 21'd3),
      site_row(rand_site()),
      mode_row(cvdp_pkg::MODE_REAL),
      site_row(rand_site()),
      mode_row(cvdp_pkg::MODE_DOT),
      site_row(rand_site())
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_site(plan[i].site, closes, predicted);
        if (closes)
          pending_totals.push_back(plan[i].typed ? plan[i].total : predicted);
      end
    end

    // Random part: four idling phases, each with two register settings.
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct = TX_IDLE_PCT[ph];
      rx_stall_pct <= RX_STALL_PCT[ph];
      for (int seg = 0; seg < 2; seg++) begin
        // Mostly short runs so that results are plentiful.
        pick = $urandom_range(9);
        if (pick < 6)
          count = cvdp_pkg::CFG_DATA_W'($urandom_range(4, 1));
        else if (pick < 9)
          count = cvdp_pkg::CFG_DATA_W'($urandom_range(40, 5));
        else
          count = cvdp_pkg::CFG_DATA_W'($urandom_range(200, 60));
        // The first setting closes a run on every site, so the long receiver
        // hold-off below backs the pipeline up into the input.
        if (ph == 0 && seg == 0)
          count = 21'd1;
        write_reg(cvdp_pkg::REG_SITE_COUNT, count);
        // Only the low two bits of a mode write matter; the rest is noise.
        write_reg(cvdp_pkg::REG_MODE, cvdp_pkg::CFG_DATA_W'($urandom));
        if ($urandom_range(1))
          write_reg(cvdp_pkg::CFG_IDX_W'($urandom_range(15, 2)),
                    cvdp_pkg::CFG_DATA_W'($urandom));
        for (int n = 0; n < 150; n++) begin
          if (ph == 0 && seg == 0 && n == 20)
            hold_req <= hold_req + 1;
          // Pause the sender until the core has handed over every owed total.
          if (n == 100)
            settle();
          send_site(rand_site(), closes, predicted);
          if (closes) pending_totals.push_back(predicted);
        end
      end
    end

    settle();
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
